/* rtl/u8sd_pkg.sv */
// ============================================================================
// u8sd_pkg
// Shared widths, byte-class constants and the queue descriptor type for the
// UTF-8 stream decoder.
// ============================================================================
package u8sd_pkg;

    // Field widths
    localparam int CP_W    = 21;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 3;

    // Descriptor queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Reset value of the error code point register (replacement character)
    localparam logic [CP_W-1:0] ERROR_VALUE_RST = 21'h00FFFD;

    // Surrogate range, rejected on completion
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // Byte classes found by the front
    typedef enum logic [2:0] {
        BC_ASCII,
        BC_LEAD2,
        BC_LEAD3,
        BC_LEAD4,
        BC_CONT,
        BC_BAD
    } t_byte_class;

    // One queued step: a run of error beats, then an optional good beat
    typedef struct packed {
        logic [LEN_W-1:0] err_cnt;
        logic             has_good;
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic             fin;
    } t_desc;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Classify one raw byte
    function automatic t_byte_class classify(input logic [BYTE_W-1:0] b);
        t_byte_class c;
        if (!b[7])                  c = BC_ASCII;
        else if (b[7:6] == 2'b10)   c = BC_CONT;
        else if (b[7:5] == 3'b110)  c = BC_LEAD2;
        else if (b[7:4] == 4'b1110) c = BC_LEAD3;
        else if (b[7:3] == 5'b11110) c = BC_LEAD4;
        else                        c = BC_BAD;
        return c;
    endfunction

endpackage

/* rtl/u8sd_front.sv */
// ============================================================================
// u8sd_front
// Accepts raw bytes, tracks the pending sequence and turns each step into a
// descriptor (error run plus optional decoded code point) for the queue.
// ============================================================================
module u8sd_front
    import u8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_final_byte,
    input  t_q_status         i_q_status,
    output logic              o_push,
    output t_desc             o_desc
);

    logic [CP_W-1:0]  r_partial, n_partial;
    logic [LEN_W-1:0] r_exp_len, n_exp_len;
    logic [LEN_W-1:0] r_held,    n_held;

    t_byte_class      cls;
    logic             accept;
    logic             pending;
    logic [CP_W-1:0]  acc;
    logic [LEN_W-1:0] held_inc;
    logic [LEN_W-1:0] err_cnt;
    logic             has_good;
    logic [CP_W-1:0]  good_cp;
    logic [LEN_W-1:0] good_len;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign pending    = (r_exp_len != '0);
    assign cls        = classify(i_byte_in);
    assign acc        = {r_partial[CP_W-7:0], i_byte_in[5:0]};
    assign held_inc   = r_held + LEN_ONE;

    // Step decode: sequence update, error count and good result
    always_comb begin
        n_partial = r_partial;
        n_exp_len = r_exp_len;
        n_held    = r_held;
        err_cnt   = '0;
        has_good  = 1'b0;
        good_cp   = '0;
        good_len  = LEN_ONE;

        if (pending && cls == BC_CONT) begin
            n_partial = acc;
            n_held    = held_inc;
            if (held_inc >= r_exp_len) begin
                if (acc >= SURR_LO && acc <= SURR_HI) begin
                    err_cnt = r_exp_len;
                end else begin
                    has_good = 1'b1;
                    good_cp  = acc;
                    good_len = r_exp_len;
                end
                n_partial = '0;
                n_exp_len = '0;
                n_held    = '0;
            end
        end else begin
            // broken sequence: one error per held byte, then decode fresh
            if (pending) begin
                err_cnt   = r_held;
                n_partial = '0;
                n_exp_len = '0;
                n_held    = '0;
            end
            unique case (cls)
                BC_ASCII: begin
                    has_good = 1'b1;
                    good_cp  = {{(CP_W-BYTE_W){1'b0}}, i_byte_in};
                end
                BC_LEAD2: begin
                    n_partial = {{(CP_W-5){1'b0}}, i_byte_in[4:0]};
                    n_exp_len = LEN_TWO;
                    n_held    = LEN_ONE;
                end
                BC_LEAD3: begin
                    n_partial = {{(CP_W-4){1'b0}}, i_byte_in[3:0]};
                    n_exp_len = LEN_THREE;
                    n_held    = LEN_ONE;
                end
                BC_LEAD4: begin
                    n_partial = {{(CP_W-3){1'b0}}, i_byte_in[2:0]};
                    n_exp_len = LEN_FOUR;
                    n_held    = LEN_ONE;
                end
                default: begin
                    err_cnt = err_cnt + LEN_ONE;
                end
            endcase
        end

        // end of stream flushes whatever is still pending
        if (i_final_byte && n_exp_len != '0) begin
            err_cnt   = err_cnt + n_held;
            n_partial = '0;
            n_exp_len = '0;
            n_held    = '0;
        end
    end

    // Descriptor toward the queue; steps with no result are dropped
    assign o_push          = accept && (has_good || err_cnt != '0);
    assign o_desc.err_cnt  = err_cnt;
    assign o_desc.has_good = has_good;
    assign o_desc.cp       = good_cp;
    assign o_desc.len      = good_len;
    assign o_desc.fin      = i_final_byte;

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_exp_len <= '0;
            r_held    <= '0;
        end else if (accept) begin
            r_partial <= n_partial;
            r_exp_len <= n_exp_len;
            r_held    <= n_held;
        end
    end

`ifndef ASSERT_OFF
    a_no_len_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp_len != LEN_ONE)
        else $error("pending sequence length of one");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_len == '0) ? (r_held == '0) : (r_held != '0 && r_held < r_exp_len))
        else $error("held byte count out of range");
`endif

endmodule

/* rtl/u8sd_queue.sv */
// ============================================================================
// u8sd_queue
// Small descriptor FIFO that decouples the byte front from the beat back.
// ============================================================================
module u8sd_queue
    import u8sd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_desc     i_desc,
    input  logic      i_pop,
    output t_desc     o_head,
    output t_q_status o_status
);

    t_desc               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;

    assign o_status.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    // Occupancy
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QUEUE_CW'(1);
            2'b01:   n_count = r_count - QUEUE_CW'(1);
            default: n_count = r_count;
        endcase
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_desc;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from empty queue");
`endif

endmodule

/* rtl/u8sd_back.sv */
// ============================================================================
// u8sd_back
// Replays each queued descriptor as result beats: its errors one per cycle
// unless stalled, then any decoded code point, into a registered output stage.
// ============================================================================
module u8sd_back
    import u8sd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_desc            i_head,
    input  t_q_status        i_q_status,
    output logic             o_pop,
    input  logic [CP_W-1:0]  i_error_value,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [CP_W-1:0]  o_code_point,
    output logic [LEN_W-1:0] o_byte_count,
    output logic             o_is_error,
    output logic             o_run_last,
    output logic             o_stream_done
);

    logic [LEN_W-1:0] r_idx;
    logic             r_out_valid;
    logic [CP_W-1:0]  r_cp;
    logic [LEN_W-1:0] r_cnt;
    logic             r_err;
    logic             r_last;
    logic             r_done;

    logic             load;
    logic             beat_err;
    logic             beat_last;

    // Beat selection within the head descriptor
    assign load      = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign beat_err  = (r_idx < i_head.err_cnt);
    assign beat_last = i_head.has_good ? (r_idx == i_head.err_cnt)
                                       : (r_idx == i_head.err_cnt - LEN_ONE);
    assign o_pop     = load && beat_last;

    // Beat counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= beat_last ? '0 : r_idx + LEN_ONE;
        end
    end

    // Output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output stage payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= beat_err ? i_error_value : i_head.cp;
            r_cnt  <= beat_err ? LEN_ONE : i_head.len;
            r_err  <= beat_err;
            r_last <= beat_last;
            r_done <= beat_last && i_head.fin;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_point  = r_cp;
    assign o_byte_count  = r_cnt;
    assign o_is_error    = r_err;
    assign o_run_last    = r_last;
    assign o_stream_done = r_done;

endmodule

/* rtl/utf8_stream_decoder_unit.sv */
// ============================================================================
// utf8_stream_decoder_unit
// Streaming UTF-8 decoder: bytes in, code points with byte lengths out.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall): one byte per beat with a flag
//   on the last byte of the stream. o_in_stall rises only when the four-entry
//   descriptor queue is full.
//   Output channel (o_out_valid / i_out_stall): one result per beat. A byte
//   that completes a character, or fails one, gives one to four beats; a
//   lead or inner continuation byte gives none. run_last marks the last beat
//   of an input byte, stream_done the last beat of the final byte.
//   Config channel (i_cfg_valid / o_cfg_ready): sets the error code point;
//   always ready. Write it only while no results are outstanding.
// Timing:
//   First beat of a byte passes the descriptor queue, then the output
//   register. A byte is taken every cycle while the queue is not full; the
//   back end sends one beat per cycle unless stalled, and the queue absorbs
//   a byte with several results. When the receiver stalls, the output
//   register holds and the queue fills, after which the input stalls.
// Reset: synchronous, clears the pending sequence, the queue and the output;
//   the error code point returns to U+FFFD.
// ============================================================================
module utf8_stream_decoder_unit
    import u8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_final_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CP_W-1:0]   o_code_point,
    output logic [LEN_W-1:0]  o_byte_count,
    output logic              o_is_error,
    output logic              o_run_last,
    output logic              o_stream_done,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CP_W-1:0]   i_cfg_data
);

    logic [CP_W-1:0] r_error_value;
    t_q_status       q_status;
    t_desc           push_desc;
    t_desc           head_desc;
    logic            push;
    logic            pop;

    // Error code point register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_value <= ERROR_VALUE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_error_value <= i_cfg_data;
        end
    end

    // Byte front
    u8sd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_byte_in    (i_byte_in),
        .i_final_byte (i_final_byte),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_desc       (push_desc)
    );

    // Descriptor queue
    u8sd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_head   (head_desc),
        .o_status (q_status)
    );

    // Beat back end
    u8sd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_desc),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .i_error_value (r_error_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_point  (o_code_point),
        .o_byte_count  (o_byte_count),
        .o_is_error    (o_is_error),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done)
    );

endmodule
